// File: src/tcgr_pkg.sv
package tcgr_pkg;

   localparam int MAX_GLYPH_ROWS = 16;
   localparam int GLYPH_COUNT    = 256;
   localparam int COORD_BITS     = 12;

   // Glyph height is capped at the store's row count and at sixteen rows.
   localparam int H_CAP       = (MAX_GLYPH_ROWS < 16) ? MAX_GLYPH_ROWS : 16;
   localparam int ROW_BITS    = $clog2(MAX_GLYPH_ROWS);
   localparam int STORE_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int SCREEN_BITS = 12;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd8;
   localparam logic [4:0]  RST_GLYPH_HEIGHT = 5'd16;
   localparam logic [11:0] RST_SCREEN_W     = 12'd640;
   localparam logic [11:0] RST_SCREEN_H     = 12'd480;
   localparam logic [23:0] RST_FOREGROUND   = 24'hFFFFFF;
   localparam logic [23:0] RST_BACKGROUND   = 24'h000000;

   typedef enum logic [1:0] {
      KIND_PUT       = 2'd0,
      KIND_BACKSPACE = 2'd1,
      KIND_CLEAR     = 2'd2,
      KIND_LOAD      = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ACT_DRAW   = 2'd0,
      ACT_SCROLL = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      CSR_GLYPH_WIDTH  = 3'd0,
      CSR_GLYPH_HEIGHT = 3'd1,
      CSR_SCREEN_W     = 3'd2,
      CSR_SCREEN_H     = 3'd3,
      CSR_FOREGROUND   = 3'd4,
      CSR_BACKGROUND   = 3'd5,
      CSR_ENABLED      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_DRAW   = 2'd0,
      CMD_SCROLL = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_LOAD   = 2'd3
   } cmd_op_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_code;
      logic [3:0]  glyph_row_index;
      logic [7:0]  glyph_bits;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [7:0]  row_pattern;
      logic [4:0]  scroll_lines;
      logic [23:0] fill_foreground;
      logic [23:0] fill_background;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  glyph_width;
      logic [4:0]  glyph_height;
      logic [11:0] screen_width_px;
      logic [11:0] screen_height_px;
      logic [23:0] foreground_rgb;
      logic [23:0] background_rgb;
      logic        enabled;
   } cfg_type;

   // One command from the front to the back unit.
   typedef struct packed {
      cmd_op_type            op;
      logic                  last;
      logic                  blank;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [7:0]            code;
      logic [3:0]            row;
      logic [7:0]            bits;
   } cmd_type;

   function automatic logic [3:0] eff_width(input logic [3:0] w);
      logic [3:0] r;
      if (w == 4'd0) begin
         r = 4'd1;
      end else if (w > 4'd8) begin
         r = 4'd8;
      end else begin
         r = w;
      end
      return r;
   endfunction

   function automatic logic [4:0] eff_height(input logic [4:0] h);
      logic [4:0] r;
      if (h == 5'd0) begin
         r = 5'd1;
      end else if (h > 5'(H_CAP)) begin
         r = 5'(H_CAP);
      end else begin
         r = h;
      end
      return r;
   endfunction

   // Keeps the top w bits of a glyph row.
   function automatic logic [7:0] keep_mask(input logic [3:0] w);
      logic [15:0] m;
      m = 16'hFF00 >> w;
      return m[7:0];
   endfunction

endpackage

// File: src/tcgr_queue.sv
module tcgr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcgr_pkg::cmd_type push_data,
   input  logic              pop,
   output tcgr_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);
   import tcgr_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]      count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = next_ptr(wr_ptr_ff);
      end
      if (pop) begin
         rd_ptr_in = next_ptr(rd_ptr_ff);
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/tcgr_front.sv
module tcgr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  tcgr_pkg::req_type req_data,
   input  tcgr_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              busy,
   output logic              q_push,
   output tcgr_pkg::cmd_type q_data
);
   import tcgr_pkg::*;

   localparam int PW       = COORD_BITS + 6;
   localparam int CNT_BITS = $clog2(SCREEN_BITS);

   typedef enum logic [5:0] {
      FR_IDLE = 6'b000001,
      FR_DIV  = 6'b000010,
      FR_MUL  = 6'b000100,
      FR_WRAP = 6'b001000,
      FR_LF   = 6'b010000,
      FR_PUSH = 6'b100000
   } front_state_type;

   front_state_type          state_ff, state_in;
   logic [COORD_BITS-1:0]    col_ff, col_in;
   logic [COORD_BITS-1:0]    line_ff, line_in;
   cmd_type                  cmd_ff, cmd_in;
   logic                     then_scroll_ff, then_scroll_in;
   logic                     is_put_ff, is_put_in;
   logic [SCREEN_BITS-1:0]   div_ff, div_in;
   logic [3:0]               rem_ff, rem_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;

   logic [3:0]               w;
   logic [4:0]               h;
   logic [4:0]               trial;
   logic                     step_ge;
   logic [3:0]               step_rem;
   logic [SCREEN_BITS-1:0]   quotient;
   logic [COORD_BITS-1:0]    col_plus1;
   logic [PW-1:0]            wrap_prod;
   logic [PW-1:0]            lf_prod;
   logic                     wrap_hit;
   logic                     scroll_hit;
   logic                     load_ok;
   logic                     code_ok;

   assign w = eff_width(cfg.glyph_width);
   assign h = eff_height(cfg.glyph_height);

   // One quotient bit per cycle for the column after a backspace wraps back a line.
   assign trial    = {rem_ff, div_ff[SCREEN_BITS-1]};
   assign step_ge  = (trial >= {1'b0, w});
   assign step_rem = step_ge ? 4'(trial - {1'b0, w}) : trial[3:0];
   assign quotient = {div_ff[SCREEN_BITS-2:0], step_ge};

   assign col_plus1  = col_ff + 1'b1;
   assign wrap_prod  = (PW'(col_plus1) + PW'(1)) * PW'(w);
   assign lf_prod    = (PW'(line_ff) + PW'(2)) * PW'(h);
   assign wrap_hit   = (wrap_prod >= PW'(cfg.screen_width_px));
   assign scroll_hit = (lf_prod >= PW'(cfg.screen_height_px));

   assign load_ok = (int'(req_data.glyph_row_index) < MAX_GLYPH_ROWS) &&
                    (int'(req_data.char_code) < GLYPH_COUNT);
   assign code_ok = (int'(req_data.char_code) < GLYPH_COUNT);

   assign busy   = (state_ff != FR_IDLE);
   assign q_data = cmd_ff;

   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      line_in        = line_ff;
      cmd_in         = cmd_ff;
      then_scroll_in = then_scroll_ff;
      is_put_in      = is_put_ff;
      div_in         = div_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      q_push         = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (start) begin
               cmd_in.op      = CMD_DRAW;
               cmd_in.code    = req_data.char_code;
               cmd_in.row     = req_data.glyph_row_index;
               cmd_in.bits    = req_data.glyph_bits;
               cmd_in.last    = 1'b1;
               cmd_in.blank   = 1'b1;
               cmd_in.x       = '0;
               cmd_in.y       = '0;
               then_scroll_in = 1'b0;
               is_put_in      = 1'b0;
               if (req_data.kind == KIND_CLEAR) begin
                  col_in    = '0;
                  line_in   = '0;
                  cmd_in.op = CMD_CLEAR;
                  state_in  = FR_PUSH;
               end else if (cfg.enabled) begin
                  case (req_data.kind)
                     KIND_LOAD: begin
                        cmd_in.op = CMD_LOAD;
                        if (load_ok) begin
                           state_in = FR_PUSH;
                        end
                     end
                     KIND_BACKSPACE: begin
                        if (col_ff != '0) begin
                           col_in   = col_ff - 1'b1;
                           state_in = FR_MUL;
                        end else if (line_ff != '0) begin
                           div_in   = cfg.screen_width_px;
                           rem_in   = '0;
                           cnt_in   = '0;
                           state_in = FR_DIV;
                        end
                     end
                     KIND_PUT: begin
                        if (req_data.char_code == CHAR_LF) begin
                           col_in   = '0;
                           state_in = FR_LF;
                        end else if (req_data.char_code == CHAR_CR) begin
                           col_in = '0;
                        end else begin
                           cmd_in.blank = !code_ok;
                           is_put_in    = 1'b1;
                           state_in     = FR_MUL;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         FR_DIV: begin
            rem_in = step_rem;
            div_in = quotient;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SCREEN_BITS - 1)) begin
               line_in  = line_ff - 1'b1;
               col_in   = (quotient == '0) ? '0 : COORD_BITS'(quotient - 1'b1);
               state_in = FR_MUL;
            end
         end
         FR_MUL: begin
            cmd_in.op = CMD_DRAW;
            cmd_in.x  = COORD_BITS'(col_ff * COORD_BITS'(w));
            cmd_in.y  = COORD_BITS'(line_ff * COORD_BITS'(h));
            state_in  = is_put_ff ? FR_WRAP : FR_PUSH;
         end
         FR_WRAP: begin
            col_in   = col_plus1;
            state_in = wrap_hit ? FR_LF : FR_PUSH;
         end
         FR_LF: begin
            col_in = '0;
            if (scroll_hit) begin
               // After a glyph, the scroll follows its rows and closes the transfer run.
               if (is_put_ff) begin
                  cmd_in.last    = 1'b0;
                  then_scroll_in = 1'b1;
               end else begin
                  cmd_in.op = CMD_SCROLL;
               end
               state_in = FR_PUSH;
            end else begin
               line_in  = line_ff + 1'b1;
               state_in = is_put_ff ? FR_PUSH : FR_IDLE;
            end
         end
         FR_PUSH: begin
            if (!q_full) begin
               q_push = 1'b1;
               if (then_scroll_ff) begin
                  cmd_in.op      = CMD_SCROLL;
                  cmd_in.last    = 1'b1;
                  then_scroll_in = 1'b0;
               end else begin
                  state_in = FR_IDLE;
               end
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FR_IDLE;
         col_ff         <= '0;
         line_ff        <= '0;
         then_scroll_ff <= 1'b0;
         is_put_ff      <= 1'b0;
         cnt_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         line_ff        <= line_in;
         then_scroll_ff <= then_scroll_in;
         is_put_ff      <= is_put_in;
         cnt_ff         <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

endmodule

// File: src/tcgr_back.sv
module tcgr_back (
   input  logic              clock,
   input  logic              reset,
   input  tcgr_pkg::cfg_type cfg,
   input  logic              q_empty,
   input  tcgr_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              rsp_strobe,
   output tcgr_pkg::rsp_type rsp_data
);
   import tcgr_pkg::*;

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_ROWS = 2'b10
   } back_state_type;

   typedef struct packed {
      action_type  action;
      logic [11:0] x;
      logic [11:0] y;
      logic        blank;
      logic        last;
   } stage_type;

   back_state_type          state_ff, state_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   cmd_type                 draw_ff, draw_in;
   logic                    s1_valid_ff, s1_valid_in;
   stage_type               s1_ff, s1_in;
   logic [7:0]              rd_data_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic [7:0]              store_mem [STORE_DEPTH];
   logic                    mem_we;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ADDR_BITS-1:0]    rd_addr;
   logic [4:0]              h;
   logic                    row_end;

   assign h       = eff_height(cfg.glyph_height);
   assign row_end = (row_ff == ROW_BITS'(h - 5'd1));
   assign wr_addr = ADDR_BITS'(int'(q_head.code) * MAX_GLYPH_ROWS + int'(q_head.row));
   assign rd_addr = ADDR_BITS'(int'(draw_ff.code) * MAX_GLYPH_ROWS + int'(row_ff));

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      draw_in     = draw_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      s1_valid_in = 1'b0;
      s1_in       = '{action: ACT_DRAW, x: '0, y: '0, blank: 1'b1, last: 1'b0};
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_head.op)
                  CMD_DRAW: begin
                     draw_in  = q_head;
                     row_in   = '0;
                     state_in = BK_ROWS;
                  end
                  CMD_SCROLL: begin
                     s1_valid_in  = 1'b1;
                     s1_in.action = ACT_SCROLL;
                     s1_in.last   = q_head.last;
                  end
                  CMD_CLEAR: begin
                     s1_valid_in  = 1'b1;
                     s1_in.action = ACT_CLEAR;
                     s1_in.last   = q_head.last;
                  end
                  CMD_LOAD: begin
                     mem_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_ROWS: begin
            // The store read for this row lands in rd_data_ff with the stage register.
            s1_valid_in  = 1'b1;
            s1_in.action = ACT_DRAW;
            s1_in.x      = 12'(draw_ff.x);
            s1_in.y      = 12'(COORD_BITS'(draw_ff.y + COORD_BITS'(row_ff)));
            s1_in.blank  = draw_ff.blank;
            s1_in.last   = draw_ff.last && row_end;
            if (row_end) begin
               state_in = BK_IDLE;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.action          = s1_ff.action;
      rsp_in.pixel_x         = s1_ff.x;
      rsp_in.pixel_y         = s1_ff.y;
      rsp_in.row_pattern     = (s1_ff.action == ACT_DRAW && !s1_ff.blank) ?
                               (rd_data_ff & keep_mask(eff_width(cfg.glyph_width))) : '0;
      rsp_in.scroll_lines    = (s1_ff.action == ACT_SCROLL) ? h : '0;
      rsp_in.fill_foreground = cfg.foreground_rgb;
      rsp_in.fill_background = cfg.background_rgb;
      rsp_in.last_of_run     = s1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr] <= q_head.bits;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      draw_ff <= draw_in;
      s1_ff   <= s1_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: src/text_console_glyph_renderer.sv
// Text console renderer: turns console items into draw-row, scroll and clear commands.
// Items enter on start/req_data and are taken at a clock edge where start is high and
// busy is low. Results leave on rsp_data, each valid for the single cycle that
// rsp_strobe is high; the consumer must take every transfer, there is no back-pressure.
// last_of_run marks the final result of an item. Registers are written through
// csr_we/csr_index/csr_wdata, and the user must do so only while no item is in
// flight; the block itself does not enforce this. The front unit classifies an item
// and updates the cursor, keeping busy high until it is done with the item. It hands
// commands to the back unit through a four-entry queue. The back unit reads one glyph
// row from the store per cycle and takes the next command only once the rows of a
// character are done. A backspace from column zero adds a divide in the front.
// Carriage return and load items give no result, nor does a line feed that does not
// scroll. Reset homes the cursor, restores the register defaults and empties the
// queue; the glyph store is not cleared and a glyph must be loaded before it is drawn.
module text_console_glyph_renderer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcgr_pkg::req_type req_data,
   output logic              rsp_strobe,
   output tcgr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata
);
   import tcgr_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_push;
   logic     q_pop;
   logic     q_empty;
   logic     q_full;
   cmd_type  q_data;
   cmd_type  q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GLYPH_WIDTH:  cfg_in.glyph_width      = csr_wdata[3:0];
            CSR_GLYPH_HEIGHT: cfg_in.glyph_height     = csr_wdata[4:0];
            CSR_SCREEN_W:     cfg_in.screen_width_px  = csr_wdata[11:0];
            CSR_SCREEN_H:     cfg_in.screen_height_px = csr_wdata[11:0];
            CSR_FOREGROUND:   cfg_in.foreground_rgb   = csr_wdata;
            CSR_BACKGROUND:   cfg_in.background_rgb   = csr_wdata;
            CSR_ENABLED:      cfg_in.enabled          = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_width      <= RST_GLYPH_WIDTH;
         cfg_ff.glyph_height     <= RST_GLYPH_HEIGHT;
         cfg_ff.screen_width_px  <= RST_SCREEN_W;
         cfg_ff.screen_height_px <= RST_SCREEN_H;
         cfg_ff.foreground_rgb   <= RST_FOREGROUND;
         cfg_ff.background_rgb   <= RST_BACKGROUND;
         cfg_ff.enabled          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcgr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_full   (q_full),
      .busy     (busy),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   tcgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   tcgr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

   a_scroll_clear_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.action != ACT_DRAW |->
         rsp_data.last_of_run && rsp_data.pixel_x == '0 && rsp_data.pixel_y == '0)
      else $error("scroll or clear transfer is not the closing result at the origin");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.kind == KIND_CLEAR |=> busy)
      else $error("clear item did not occupy the front unit");

endmodule

// File: verif/tcgr_scoreboard.sv
`timescale 1ns / 100ps

module tcgr_scoreboard (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  tcgr_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  tcgr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata,
   output int                outstanding,
   output int                fail_count
);
   import tcgr_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int COORD_MASK   = (1 << COORD_BITS) - 1;

   logic [3:0]  glyph_w;
   logic [4:0]  glyph_h;
   logic [11:0] scr_w;
   logic [11:0] scr_h;
   logic [23:0] fg_rgb;
   logic [23:0] bg_rgb;
   logic        console_on;

   int          cur_col;
   int          cur_row;
   logic [7:0]  glyph_rows [STORE_DEPTH];
   rsp_type     console_ops_q [$];
   int          errors = 0;

   function automatic int cell_width();
      int w;
      w = int'(glyph_w);
      if (w == 0) begin
         w = 1;
      end else if (w > 8) begin
         w = 8;
      end
      return w;
   endfunction

   function automatic int cell_height();
      int h;
      h = int'(glyph_h);
      if (h == 0) begin
         h = 1;
      end else if (h > H_CAP) begin
         h = H_CAP;
      end
      return h;
   endfunction

   task automatic emit_op(input action_type act, input int x, input int y,
                          input logic [7:0] pattern, input int lines);
      rsp_type op;
      op.action          = act;
      op.pixel_x         = 12'(x & COORD_MASK);
      op.pixel_y         = 12'(y & COORD_MASK);
      op.row_pattern     = pattern;
      op.scroll_lines    = 5'(lines);
      op.fill_foreground = fg_rgb;
      op.fill_background = bg_rgb;
      op.last_of_run     = 1'b0;
      console_ops_q.push_back(op);
   endtask

   // The cursor stays on its line when the next one would not fit on screen.
   task automatic new_line();
      int h;
      int next_row;
      h        = cell_height();
      next_row = cur_row + 1;
      cur_col  = 0;
      if ((next_row + 1) * h >= int'(scr_h)) begin
         emit_op(ACT_SCROLL, 0, 0, 8'h00, h);
      end else begin
         cur_row = next_row & COORD_MASK;
      end
   endtask

   task automatic draw_cell(input logic [7:0] code, input logic blank);
      int w;
      int h;
      logic [7:0] keep;
      logic [7:0] bits;
      w    = cell_width();
      h    = cell_height();
      keep = ~(8'hFF >> w);
      for (int r = 0; r < h; r++) begin
         bits = blank ? 8'h00 : glyph_rows[int'(code) * MAX_GLYPH_ROWS + r];
         emit_op(ACT_DRAW, cur_col * w, cur_row * h + r, bits & keep, 0);
      end
   endtask

   task automatic render_item(input req_type item);
      int first;
      int cols;
      rsp_type tail;
      first = console_ops_q.size();
      if (item.kind == KIND_CLEAR) begin
         cur_col = 0;
         cur_row = 0;
         emit_op(ACT_CLEAR, 0, 0, 8'h00, 0);
      end else if (console_on) begin
         case (item.kind)
            KIND_LOAD: begin
               if (int'(item.char_code) < GLYPH_COUNT &&
                   int'(item.glyph_row_index) < MAX_GLYPH_ROWS) begin
                  glyph_rows[int'(item.char_code) * MAX_GLYPH_ROWS +
                             int'(item.glyph_row_index)] = item.glyph_bits;
               end
            end
            KIND_BACKSPACE: begin
               if (cur_col != 0 || cur_row != 0) begin
                  if (cur_col == 0) begin
                     cols    = int'(scr_w) / cell_width();
                     cur_row = (cur_row - 1) & COORD_MASK;
                     cur_col = (cols == 0) ? 0 : cols - 1;
                  end else begin
                     cur_col = cur_col - 1;
                  end
                  draw_cell(8'h00, 1'b1);
               end
            end
            default: begin
               if (item.char_code == CHAR_LF) begin
                  new_line();
               end else if (item.char_code == CHAR_CR) begin
                  cur_col = 0;
               end else begin
                  draw_cell(item.char_code, 1'b0);
                  cur_col = (cur_col + 1) & COORD_MASK;
                  if ((cur_col + 1) * cell_width() >= int'(scr_w)) begin
                     new_line();
                  end
               end
            end
         endcase
      end
      if (console_ops_q.size() > first) begin
         tail = console_ops_q.pop_back();
         tail.last_of_run = 1'b1;
         console_ops_q.push_back(tail);
      end
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [23:0] data);
      case (index)
         CSR_GLYPH_WIDTH:  glyph_w    = data[3:0];
         CSR_GLYPH_HEIGHT: glyph_h    = data[4:0];
         CSR_SCREEN_W:     scr_w      = data[11:0];
         CSR_SCREEN_H:     scr_h      = data[11:0];
         CSR_FOREGROUND:   fg_rgb     = data;
         CSR_BACKGROUND:   bg_rgb     = data;
         CSR_ENABLED:      console_on = data[0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         glyph_w    = RST_GLYPH_WIDTH;
         glyph_h    = RST_GLYPH_HEIGHT;
         scr_w      = RST_SCREEN_W;
         scr_h      = RST_SCREEN_H;
         fg_rgb     = RST_FOREGROUND;
         bg_rgb     = RST_BACKGROUND;
         console_on = 1'b0;
         cur_col    = 0;
         cur_row    = 0;
         console_ops_q.delete();
         errors     = 0;
      end else begin
         if (start && !busy) begin
            render_item(req_data);
         end
         if (csr_we) begin
            write_reg(csr_index, csr_wdata);
         end
         if (rsp_strobe) begin
            if (console_ops_q.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: result transfer with nothing expected, act=%0d x=%0d y=%0d",
                           $time, rsp_data.action, rsp_data.pixel_x, rsp_data.pixel_y);
               end
            end else begin
               want = console_ops_q.pop_front();
               if (rsp_data.action !== want.action ||
                   rsp_data.pixel_x !== want.pixel_x ||
                   rsp_data.pixel_y !== want.pixel_y ||
                   rsp_data.row_pattern !== want.row_pattern ||
                   rsp_data.scroll_lines !== want.scroll_lines ||
                   rsp_data.fill_foreground !== want.fill_foreground ||
                   rsp_data.fill_background !== want.fill_background ||
                   rsp_data.last_of_run !== want.last_of_run) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display("%0t: expected act=%0d x=%0d y=%0d pat=%02h lines=%0d %s",
                              $time, want.action, want.pixel_x, want.pixel_y,
                              want.row_pattern, want.scroll_lines,
                              $sformatf("fg=%06h bg=%06h last=%0b", want.fill_foreground,
                                        want.fill_background, want.last_of_run));
                     $display("%0t: actual   act=%0d x=%0d y=%0d pat=%02h lines=%0d %s",
                              $time, rsp_data.action, rsp_data.pixel_x, rsp_data.pixel_y,
                              rsp_data.row_pattern, rsp_data.scroll_lines,
                              $sformatf("fg=%06h bg=%06h last=%0b",
                                        rsp_data.fill_foreground,
                                        rsp_data.fill_background, rsp_data.last_of_run));
                  end
               end
            end
         end
      end
      outstanding = console_ops_q.size();
      fail_count  = errors + console_ops_q.size();
   end

endmodule

// File: verif/tb_text_console_glyph_renderer.sv
`timescale 1ns / 100ps

module tb_text_console_glyph_renderer;
   import tcgr_pkg::*;

   localparam int RANDOM_ITEMS  = 430;
   localparam int PHASE_ITEMS   = 72;
   localparam int SETTLE_CYCLES = 60;
   localparam int QUIET_LIMIT   = 4000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   int          outstanding;
   int          fail_count;
   int          quiet_cycles;
   int          counted_items;
   int          phase;
   int          phase_end;
   logic        held;
   logic        steady;
   logic        enabled_now;
   logic [15:0] rows_loaded [GLYPH_COUNT];
   logic [7:0]  ready_codes [$];

   text_console_glyph_renderer u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tcgr_scoreboard u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic req_type make_item(input kind_type kind, input logic [7:0] code,
                                         input logic [3:0] row, input logic [7:0] bits);
      req_type item;
      item.kind            = kind;
      item.char_code       = code;
      item.glyph_row_index = row;
      item.glyph_bits      = bits;
      return item;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) begin
         return 0;
      end
      if (r < 85) begin
         return $urandom_range(1, 3);
      end
      if (r < 96) begin
         return $urandom_range(4, 15);
      end
      return $urandom_range(20, 70);
   endfunction

   // Holds start high until the transfer happens, then idles for a random gap, which may be zero.
   task automatic transfer(input req_type item);
      int gap;
      start    = 1'b1;
      req_data = item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (enabled_now || item.kind == KIND_CLEAR) begin
         counted_items++;
      end
      if (enabled_now && item.kind == KIND_LOAD) begin
         rows_loaded[item.char_code][item.glyph_row_index] = 1'b1;
      end
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic csr_write(input csr_index_type index, input logic [23:0] value);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      if (index == CSR_ENABLED) begin
         enabled_now = value[0];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Loads, CR and non-scrolling LF items give no result, so the block may still
   // be busy after the last expected transfer; give it time before touching registers.
   task automatic settle();
      start = 1'b0;
      while (outstanding != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_glyph(input logic [7:0] code);
      for (int r = 0; r < MAX_GLYPH_ROWS; r++) begin
         transfer(make_item(KIND_LOAD, code, 4'(r), 8'($urandom)));
      end
      if (enabled_now) begin
         ready_codes.push_back(code);
      end
   endtask

   task automatic random_item();
      int pick;
      logic [7:0] code;
      pick = $urandom_range(0, 99);
      code = 8'($urandom);
      if (ready_codes.size() == 0 || pick < 4) begin
         load_glyph(code);
      end else if (pick < 55) begin
         // Only glyphs whose rows were all loaded may be drawn.
         if (code != CHAR_LF && code != CHAR_CR && rows_loaded[code] != 16'hFFFF) begin
            code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
         end
         transfer(make_item(KIND_PUT, code, 4'($urandom), 8'($urandom)));
      end else if (pick < 67) begin
         transfer(make_item(KIND_PUT, CHAR_LF, 4'($urandom), 8'($urandom)));
      end else if (pick < 73) begin
         transfer(make_item(KIND_PUT, CHAR_CR, 4'($urandom), 8'($urandom)));
      end else if (pick < 88) begin
         transfer(make_item(KIND_BACKSPACE, code, 4'($urandom), 8'($urandom)));
      end else if (pick < 91) begin
         transfer(make_item(KIND_CLEAR, code, 4'($urandom), 8'($urandom)));
      end else begin
         transfer(make_item(KIND_LOAD, code, 4'($urandom), 8'($urandom)));
      end
   endtask

   task automatic setup_phase(input int which);
      logic [23:0] fg;
      logic [23:0] bg;
      fg = 24'($urandom);
      bg = 24'($urandom);
      case (which)
         0: begin
            csr_write(CSR_GLYPH_WIDTH, 24'd8);
            csr_write(CSR_GLYPH_HEIGHT, 24'd16);
            csr_write(CSR_SCREEN_W, 24'd640);
            csr_write(CSR_SCREEN_H, 24'd480);
         end
         1: begin
            // Zero sizes are taken as one; a one-pixel screen wraps and scrolls always.
            csr_write(CSR_GLYPH_WIDTH, 24'd0);
            csr_write(CSR_GLYPH_HEIGHT, 24'd0);
            csr_write(CSR_SCREEN_W, 24'd1);
            csr_write(CSR_SCREEN_H, 24'd1);
            fg = 24'h000000;
            bg = 24'hFFFFFF;
         end
         2: begin
            csr_write(CSR_GLYPH_WIDTH, 24'd15);
            csr_write(CSR_GLYPH_HEIGHT, 24'd31);
            csr_write(CSR_SCREEN_W, 24'd4095);
            csr_write(CSR_SCREEN_H, 24'd4095);
            fg = 24'hFFFFFF;
            bg = 24'h000000;
         end
         3: begin
            csr_write(CSR_GLYPH_WIDTH, 24'($urandom_range(1, 8)));
            csr_write(CSR_GLYPH_HEIGHT, 24'($urandom_range(1, 16)));
            csr_write(CSR_SCREEN_W, 24'($urandom_range(8, 160)));
            csr_write(CSR_SCREEN_H, 24'($urandom_range(8, 160)));
         end
         5: begin
            csr_write(CSR_GLYPH_WIDTH, 24'd8);
            csr_write(CSR_GLYPH_HEIGHT, 24'd1);
            csr_write(CSR_SCREEN_W, 24'd64);
            csr_write(CSR_SCREEN_H, 24'd8);
         end
         default: begin
            csr_write(CSR_GLYPH_WIDTH, 24'($urandom_range(0, 15)));
            csr_write(CSR_GLYPH_HEIGHT, 24'($urandom_range(0, 31)));
            csr_write(CSR_SCREEN_W, 24'($urandom_range(1, 4095)));
            csr_write(CSR_SCREEN_H, 24'($urandom_range(1, 4095)));
         end
      endcase
      csr_write(CSR_FOREGROUND, fg);
      csr_write(CSR_BACKGROUND, bg);
   endtask

   // With the console stopped every item but clear is dropped.
   task automatic disabled_stretch();
      settle();
      csr_write(CSR_ENABLED, 24'd0);
      repeat (12) begin
         transfer(make_item(kind_type'($urandom_range(0, 3)), 8'($urandom),
                            4'($urandom), 8'($urandom)));
      end
      settle();
      csr_write(CSR_ENABLED, 24'd1);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      enabled_now   = 1'b0;
      steady        = 1'b0;
      counted_items = 0;
      for (int c = 0; c < GLYPH_COUNT; c++) begin
         rows_loaded[c] = '0;
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Console still stopped after reset.
      transfer(make_item(KIND_PUT, 8'h41, 4'h0, 8'h00));
      transfer(make_item(KIND_LOAD, 8'h41, 4'h0, 8'hFF));
      transfer(make_item(KIND_BACKSPACE, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_CLEAR, 8'hFF, 4'hF, 8'hFF));
      settle();
      csr_write(CSR_ENABLED, 24'd1);
      csr_write(CSR_GLYPH_HEIGHT, 24'd2);

      transfer(make_item(KIND_LOAD, 8'hFF, 4'h0, 8'hFF));
      transfer(make_item(KIND_LOAD, 8'hFF, 4'h1, 8'h81));
      transfer(make_item(KIND_LOAD, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_LOAD, 8'h00, 4'h1, 8'h7E));
      transfer(make_item(KIND_LOAD, 8'hFF, 4'hF, 8'hA5));
      transfer(make_item(KIND_PUT, 8'hFF, 4'hF, 8'hFF));
      transfer(make_item(KIND_PUT, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_PUT, CHAR_CR, 4'h0, 8'h00));
      transfer(make_item(KIND_PUT, 8'hFF, 4'h0, 8'h00));
      transfer(make_item(KIND_PUT, CHAR_LF, 4'h0, 8'h00));
      // From column zero of the second line back to the end of the first one.
      transfer(make_item(KIND_BACKSPACE, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_BACKSPACE, 8'hFF, 4'hF, 8'hFF));
      transfer(make_item(KIND_PUT, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_CLEAR, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_BACKSPACE, 8'h00, 4'h0, 8'h00));
      transfer(make_item(KIND_PUT, 8'hFF, 4'h0, 8'h00));

      counted_items = 0;
      phase         = 0;
      while (counted_items < RANDOM_ITEMS) begin
         settle();
         setup_phase(phase);
         steady    = (phase == 2 || phase == 5);
         phase_end = counted_items + PHASE_ITEMS;
         held      = 1'b0;
         while (counted_items < phase_end) begin
            random_item();
            if (!held && counted_items >= phase_end - PHASE_ITEMS / 2) begin
               // Hold the next transfer until every expected result is back.
               start = 1'b0;
               while (outstanding != 0) begin
                  @(negedge clock);
               end
               held = 1'b1;
            end
         end
         if (phase == 3) begin
            disabled_stretch();
         end
         phase++;
      end

      settle();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
src/tcgr_pkg.sv
src/tcgr_queue.sv
src/tcgr_front.sv
src/tcgr_back.sv
src/text_console_glyph_renderer.sv
verif/tcgr_scoreboard.sv
verif/tb_text_console_glyph_renderer.sv
